// ----- hdl/mmp_pkg.sv -----
// ----------------------------------------------------------------------------
// mmp_pkg
// Shared types and constants for the multiport MIDI message parser.
// ----------------------------------------------------------------------------
package mmp_pkg;

    localparam int NUM_PORTS   = 7;
    localparam int PORT_W      = 3;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PORT_ENABLE,
        CFG_MAX_SYSEX
    } cfg_reg_t;

    localparam logic [7:0] SYSEX_START    = 8'hf0;
    localparam logic [7:0] SYSEX_STOP     = 8'hf7;
    localparam logic [7:0] TIME_CODE      = 8'hf1;
    localparam logic [7:0] SONG_POSITION  = 8'hf2;
    localparam logic [7:0] SONG_SELECT    = 8'hf3;
    localparam logic [7:0] SINGLE_BYTE_LO = 8'hf4;
    localparam logic [3:0] HI_PROG_CHANGE = 4'hc;
    localparam logic [3:0] HI_PRESSURE    = 4'hd;
    localparam logic [3:0] HI_PITCH_BEND  = 4'he;
    localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
    localparam logic [3:0] HI_CONTROL     = 4'hb;

    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_SYSEX = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_STATUS,
        PH_DATA,
        PH_SYSEX
    } phase_t;

    typedef struct packed {
        phase_t      phase;
        logic [7:0]  held_status;
        logic [7:0]  held_first;
        logic [15:0] sysex_count;
        logic        overflowed;
    } port_state_t;

    typedef struct packed {
        logic       kind;
        logic [7:0] first_byte;
        logic [7:0] second_byte;
        logic [7:0] third_byte;
        logic [1:0] byte_count;
        logic       sysex_end;
    } msg_t;

    typedef struct packed {
        logic [NUM_PORTS-1:0] valid;
        msg_t [NUM_PORTS-1:0] msg;
    } bundle_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic two_byte_channel(input logic [7:0] s);
        return (s[7:4] == HI_PROG_CHANGE) || (s[7:4] == HI_PRESSURE);
    endfunction

    function automatic logic three_byte_channel(input logic [7:0] s);
        return (s[7:4] >= HI_NOTE_OFF && s[7:4] <= HI_CONTROL)
            || (s[7:4] == HI_PITCH_BEND);
    endfunction

endpackage

// ----- hdl/mmp_if.sv -----
// ----------------------------------------------------------------------------
// mmp_if
// Channel interfaces: input packet, result word and configuration write.
// ----------------------------------------------------------------------------
interface mmp_packet_if;
    logic       valid;
    logic       ready;
    logic [6:0] valid_mask;
    logic [7:0] port0_byte;
    logic [7:0] port1_byte;
    logic [7:0] port2_byte;
    logic [7:0] port3_byte;
    logic [7:0] port4_byte;
    logic [7:0] port5_byte;
    logic [7:0] port6_byte;

    modport source
    (
        output valid, valid_mask, port0_byte, port1_byte, port2_byte,
               port3_byte, port4_byte, port5_byte, port6_byte,
        input  ready
    );
    modport sink
    (
        input  valid, valid_mask, port0_byte, port1_byte, port2_byte,
               port3_byte, port4_byte, port5_byte, port6_byte,
        output ready
    );
endinterface

interface mmp_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] source_port;
    logic       kind;
    logic [7:0] first_byte;
    logic [7:0] second_byte;
    logic [7:0] third_byte;
    logic [1:0] byte_count;
    logic       sysex_end;
    logic       last_of_packet;

    modport source
    (
        output valid, source_port, kind, first_byte, second_byte, third_byte,
               byte_count, sysex_end, last_of_packet,
        input  ready
    );
    modport sink
    (
        input  valid, source_port, kind, first_byte, second_byte, third_byte,
               byte_count, sysex_end, last_of_packet,
        output ready
    );
endinterface

interface mmp_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [mmp_pkg::CFG_IDX_W-1:0] index;
    logic [mmp_pkg::CFG_DATA_W-1:0] data;

    modport source
    (
        output valid, index, data,
        input  ready
    );
    modport sink
    (
        input  valid, index, data,
        output ready
    );
endinterface

// ----- hdl/mmp_port_parser.sv -----
// ----------------------------------------------------------------------------
// mmp_port_parser
// Byte parser for one port: running status, short messages, streamed sysex.
// ----------------------------------------------------------------------------
module mmp_port_parser
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic [7:0]        in_byte,
    input  logic [15:0]       max_len,
    output mmp_pkg::msg_t     msg,
    output logic              msg_valid
);

    mmp_pkg::port_state_t state_reg;
    mmp_pkg::port_state_t state_next;

    logic       is_data;
    logic [7:0] st;

    assign is_data = ~in_byte[7];
    assign st      = state_reg.held_status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        if (en)
        begin
            case (state_reg.phase)
                mmp_pkg::PH_IDLE:
                begin
                    if (in_byte >= mmp_pkg::SINGLE_BYTE_LO && in_byte != mmp_pkg::SYSEX_STOP)
                    begin
                        state_next = state_reg;
                    end
                    else if (!is_data)
                    begin
                        if (in_byte != mmp_pkg::SYSEX_STOP)
                        begin
                            state_next.held_status = in_byte;
                            state_next.phase       = mmp_pkg::PH_STATUS;
                        end
                    end
                    else if (!mmp_pkg::two_byte_channel(st)
                             && mmp_pkg::three_byte_channel(st))
                    begin
                        state_next.held_first = in_byte;
                        state_next.phase      = mmp_pkg::PH_DATA;
                    end
                end
                mmp_pkg::PH_STATUS:
                begin
                    if (mmp_pkg::two_byte_channel(st) || st == mmp_pkg::TIME_CODE
                        || st == mmp_pkg::SONG_SELECT || !is_data)
                    begin
                        state_next.phase = mmp_pkg::PH_IDLE;
                    end
                    else
                    begin
                        state_next.held_first = in_byte;
                        state_next.phase      = mmp_pkg::PH_DATA;
                    end
                end
                mmp_pkg::PH_DATA:
                begin
                    if (st == mmp_pkg::SYSEX_START && in_byte == mmp_pkg::SYSEX_STOP)
                    begin
                        state_next.phase       = mmp_pkg::PH_IDLE;
                        state_next.held_status = 8'h00;
                    end
                    else if (st == mmp_pkg::SYSEX_START)
                    begin
                        state_next.phase       = mmp_pkg::PH_SYSEX;
                        state_next.sysex_count = 16'd3;
                        state_next.overflowed  = 1'b0;
                    end
                    else
                    begin
                        state_next.phase = mmp_pkg::PH_IDLE;
                    end
                end
                mmp_pkg::PH_SYSEX:
                begin
                    if (in_byte == mmp_pkg::SYSEX_STOP)
                    begin
                        state_next.phase       = mmp_pkg::PH_IDLE;
                        state_next.held_status = 8'h00;
                        state_next.sysex_count = 16'd0;
                        state_next.overflowed  = 1'b0;
                    end
                    else if (!state_reg.overflowed && state_reg.sysex_count < max_len)
                    begin
                        state_next.sysex_count = state_reg.sysex_count + 16'd1;
                    end
                    else
                    begin
                        state_next.overflowed = 1'b1;
                    end
                end
                default:
                begin
                    state_next = state_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        msg       = '0;
        msg_valid = 1'b0;
        if (en)
        begin
            case (state_reg.phase)
                mmp_pkg::PH_IDLE:
                begin
                    if (in_byte >= mmp_pkg::SINGLE_BYTE_LO && in_byte != mmp_pkg::SYSEX_STOP)
                    begin
                        msg_valid       = 1'b1;
                        msg.kind        = mmp_pkg::KIND_SHORT;
                        msg.first_byte  = in_byte;
                        msg.byte_count  = 2'd1;
                    end
                    else if (is_data && mmp_pkg::two_byte_channel(st))
                    begin
                        msg_valid       = 1'b1;
                        msg.kind        = mmp_pkg::KIND_SHORT;
                        msg.first_byte  = st;
                        msg.second_byte = in_byte;
                        msg.byte_count  = 2'd2;
                    end
                end
                mmp_pkg::PH_STATUS:
                begin
                    if ((mmp_pkg::two_byte_channel(st) || st == mmp_pkg::TIME_CODE
                         || st == mmp_pkg::SONG_SELECT) && is_data)
                    begin
                        msg_valid       = 1'b1;
                        msg.kind        = mmp_pkg::KIND_SHORT;
                        msg.first_byte  = st;
                        msg.second_byte = in_byte;
                        msg.byte_count  = 2'd2;
                    end
                end
                mmp_pkg::PH_DATA:
                begin
                    if (st == mmp_pkg::SYSEX_START)
                    begin
                        msg_valid       = 1'b1;
                        msg.kind        = mmp_pkg::KIND_SYSEX;
                        msg.first_byte  = mmp_pkg::SYSEX_START;
                        msg.second_byte = state_reg.held_first;
                        msg.third_byte  = in_byte;
                        msg.byte_count  = 2'd3;
                        msg.sysex_end   = (in_byte == mmp_pkg::SYSEX_STOP);
                    end
                    else if (is_data && (mmp_pkg::three_byte_channel(st)
                                         || st == mmp_pkg::SONG_POSITION))
                    begin
                        msg_valid       = 1'b1;
                        msg.kind        = mmp_pkg::KIND_SHORT;
                        msg.first_byte  = st;
                        msg.second_byte = state_reg.held_first;
                        msg.third_byte  = in_byte;
                        msg.byte_count  = 2'd3;
                    end
                end
                mmp_pkg::PH_SYSEX:
                begin
                    if (in_byte == mmp_pkg::SYSEX_STOP
                        || (!state_reg.overflowed && state_reg.sysex_count < max_len))
                    begin
                        msg_valid       = 1'b1;
                        msg.kind        = mmp_pkg::KIND_SYSEX;
                        msg.first_byte  = in_byte;
                        msg.byte_count  = 2'd1;
                        msg.sysex_end   = (in_byte == mmp_pkg::SYSEX_STOP);
                    end
                end
                default:
                begin
                    msg_valid = 1'b0;
                end
            endcase
        end
    end

endmodule

// ----- hdl/mmp_front.sv -----
// ----------------------------------------------------------------------------
// mmp_front
// Accepts packets and config writes, runs the per-port parsers in parallel
// and pushes the resulting words of a packet as one bundle into the queue.
// ----------------------------------------------------------------------------
module mmp_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    mmp_packet_if.sink             packet,
    mmp_cfg_if.sink                cfg,
    input  mmp_pkg::queue_status_t q_status,
    output logic                   push,
    output mmp_pkg::bundle_t       push_bundle
);

    logic [mmp_pkg::NUM_PORTS-1:0] port_enable_reg;
    logic [mmp_pkg::NUM_PORTS-1:0] port_enable_next;
    logic [15:0]                   max_len_reg;
    logic [15:0]                   max_len_next;

    logic                          accept;
    logic [mmp_pkg::NUM_PORTS-1:0] port_en;
    logic [7:0]                    port_byte [mmp_pkg::NUM_PORTS];

    assign cfg.ready    = 1'b1;
    assign packet.ready = ~q_status.full;
    assign accept       = packet.valid & packet.ready;

    assign port_byte[0] = packet.port0_byte;
    assign port_byte[1] = packet.port1_byte;
    assign port_byte[2] = packet.port2_byte;
    assign port_byte[3] = packet.port3_byte;
    assign port_byte[4] = packet.port4_byte;
    assign port_byte[5] = packet.port5_byte;
    assign port_byte[6] = packet.port6_byte;

    assign port_en = {mmp_pkg::NUM_PORTS{accept}} & packet.valid_mask & port_enable_reg;

    always_comb
    begin
        port_enable_next = port_enable_reg;
        max_len_next     = max_len_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                mmp_pkg::CFG_PORT_ENABLE: port_enable_next = cfg.data[mmp_pkg::NUM_PORTS-1:0];
                mmp_pkg::CFG_MAX_SYSEX:   max_len_next     = cfg.data;
                default:                  max_len_next     = max_len_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_enable_reg <= '1;
            max_len_reg     <= 16'hffff;
        end
        else
        begin
            port_enable_reg <= port_enable_next;
            max_len_reg     <= max_len_next;
        end
    end

    for (genvar i = 0; i < mmp_pkg::NUM_PORTS; i++)
    begin : g_port
        mmp_port_parser u_parser
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (port_en[i]),
            .in_byte   (port_byte[i]),
            .max_len   (max_len_reg),
            .msg       (push_bundle.msg[i]),
            .msg_valid (push_bundle.valid[i])
        );
    end

    // packets that yield nothing never enter the queue
    assign push = accept & (|push_bundle.valid);

endmodule

// ----- hdl/mmp_queue.sv -----
// ----------------------------------------------------------------------------
// mmp_queue
// Short FIFO of per-packet result bundles between front and back.
// ----------------------------------------------------------------------------
module mmp_queue
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  mmp_pkg::bundle_t       push_bundle,
    input  logic                   pop,
    output mmp_pkg::bundle_t       head,
    output mmp_pkg::queue_status_t q_status
);

    mmp_pkg::bundle_t            mem_reg [mmp_pkg::QUEUE_DEPTH];
    logic [mmp_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [mmp_pkg::QPTR_W-1:0]  wr_ptr_next;
    logic [mmp_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [mmp_pkg::QPTR_W-1:0]  rd_ptr_next;
    logic [mmp_pkg::QCNT_W-1:0]  count_reg;
    logic [mmp_pkg::QCNT_W-1:0]  count_next;

    localparam logic [mmp_pkg::QPTR_W-1:0] PTR_LAST = mmp_pkg::QPTR_W'(mmp_pkg::QUEUE_DEPTH - 1);
    localparam logic [mmp_pkg::QCNT_W-1:0] CNT_FULL = mmp_pkg::QCNT_W'(mmp_pkg::QUEUE_DEPTH);
    localparam logic [mmp_pkg::QCNT_W-1:0] CNT_ONE  = mmp_pkg::QCNT_W'(1);

    assign head           = mem_reg[rd_ptr_reg];
    assign q_status.full  = (count_reg == CNT_FULL);
    assign q_status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_bundle;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (count_reg != CNT_FULL))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("queue pop while empty");
`endif

endmodule

// ----- hdl/mmp_back.sv -----
// ----------------------------------------------------------------------------
// mmp_back
// Unpacks bundles into result words in port order, one word per cycle while
// the receiver is ready, through a registered output stage.
// ----------------------------------------------------------------------------
module mmp_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  mmp_pkg::queue_status_t q_status,
    input  mmp_pkg::bundle_t       head,
    output logic                   pop,
    mmp_result_if.source           result
);

    logic [mmp_pkg::NUM_PORTS-1:0] cur_valid_reg;
    logic [mmp_pkg::NUM_PORTS-1:0] cur_valid_next;
    mmp_pkg::msg_t [mmp_pkg::NUM_PORTS-1:0] cur_msg_reg;
    mmp_pkg::msg_t [mmp_pkg::NUM_PORTS-1:0] cur_msg_next;

    logic                       out_valid_reg;
    logic                       out_valid_next;
    mmp_pkg::msg_t              out_msg_reg;
    mmp_pkg::msg_t              out_msg_next;
    logic [mmp_pkg::PORT_W-1:0] out_port_reg;
    logic [mmp_pkg::PORT_W-1:0] out_port_next;
    logic                       out_last_reg;
    logic                       out_last_next;

    logic                          out_free;
    logic                          emit;
    logic [mmp_pkg::NUM_PORTS-1:0] remaining;
    logic [mmp_pkg::PORT_W-1:0]    sel;

    assign out_free  = ~out_valid_reg | result.ready;
    assign emit      = out_free & (|cur_valid_reg);
    assign remaining = cur_valid_reg & (cur_valid_reg - mmp_pkg::NUM_PORTS'(1));
    assign pop       = ~q_status.empty & ((cur_valid_reg == '0) | (emit & (remaining == '0)));

    always_comb
    begin
        sel = '0;
        for (int i = mmp_pkg::NUM_PORTS - 1; i >= 0; i--)
        begin
            if (cur_valid_reg[i])
            begin
                sel = mmp_pkg::PORT_W'(i);
            end
        end
    end

    always_comb
    begin
        cur_valid_next = cur_valid_reg;
        cur_msg_next   = cur_msg_reg;
        out_valid_next = out_valid_reg & ~result.ready;
        out_msg_next   = out_msg_reg;
        out_port_next  = out_port_reg;
        out_last_next  = out_last_reg;
        if (emit)
        begin
            cur_valid_next = remaining;
            out_valid_next = 1'b1;
            out_msg_next   = cur_msg_reg[sel];
            out_port_next  = sel;
            out_last_next  = (remaining == '0);
        end
        if (pop)
        begin
            cur_valid_next = head.valid;
            cur_msg_next   = head.msg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cur_valid_reg <= cur_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_msg_reg  <= cur_msg_next;
        out_msg_reg  <= out_msg_next;
        out_port_reg <= out_port_next;
        out_last_reg <= out_last_next;
    end

    assign result.valid          = out_valid_reg;
    assign result.source_port    = out_port_reg;
    assign result.kind           = out_msg_reg.kind;
    assign result.first_byte     = out_msg_reg.first_byte;
    assign result.second_byte    = out_msg_reg.second_byte;
    assign result.third_byte     = out_msg_reg.third_byte;
    assign result.byte_count     = out_msg_reg.byte_count;
    assign result.sysex_end      = out_msg_reg.sysex_end;
    assign result.last_of_packet = out_last_reg;

`ifndef SYNTH
    a_stall_keeps_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !result.ready && cur_valid_reg != '0) |=> $stable(cur_valid_reg))
        else $error("pending words changed while output stalled");

    a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_msg_reg.byte_count != 2'd0))
        else $error("result word with zero byte count");
`endif

endmodule

// ----- hdl/midi_multiport_message_parser.sv -----
// ----------------------------------------------------------------------------
// midi_multiport_message_parser
// Seven-port MIDI parser with running status and streamed system exclusive.
// ----------------------------------------------------------------------------
// Channels: packet (valid_mask plus one byte per port), result (one parsed
// message or sysex fragment per word) and cfg (index 0 port_enable, index 1
// max_sysex_length; cfg.ready is always high, write only while idle).
// A packet is parsed on every enabled, present port in the cycle it is
// accepted; its words then leave in ascending port order, one per cycle while
// the receiver is ready, with last_of_packet on the final one. Packets that
// yield no word leave nothing behind.
// The first word of a packet passes through the bundle queue, the bundle
// register and the output register. Throughput: one packet per cycle is
// accepted while the two-entry bundle queue has room; the output stage
// drains one word per cycle while the receiver is ready, up to 7 per packet.
// A stalled receiver holds the output word; the queue then fills and
// packet.ready drops. Reset clears all port state to idle and sets
// port_enable to all ones and max_sysex_length to 65535.
// ----------------------------------------------------------------------------
module midi_multiport_message_parser
(
    input  logic          clk,
    input  logic          rst_n,
    mmp_packet_if.sink    packet,
    mmp_cfg_if.sink       cfg,
    mmp_result_if.source  result
);

    mmp_pkg::queue_status_t q_status;
    mmp_pkg::bundle_t       push_bundle;
    mmp_pkg::bundle_t       head;
    logic                   push;
    logic                   pop;

    mmp_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .packet      (packet),
        .cfg         (cfg),
        .q_status    (q_status),
        .push        (push),
        .push_bundle (push_bundle)
    );

    mmp_queue u_queue
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .push_bundle (push_bundle),
        .pop         (pop),
        .head        (head),
        .q_status    (q_status)
    );

    mmp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_status (q_status),
        .head     (head),
        .pop      (pop),
        .result   (result)
    );

endmodule

// ----- tb/sv/midi_word_checker.sv -----
// ----------------------------------------------------------------------------
// midi_word_checker
// Watches the packet, configuration and result channels of the multiport
// MIDI parser. Every accepted packet is parsed by a per-port model of the
// running-status and sysex rules. The words it yields are queued in port
// order, and each result word is compared field by field with the oldest
// queued word.
// ----------------------------------------------------------------------------
module midi_word_checker
    import mmp_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    mmp_packet_if packet,
    mmp_cfg_if    cfg,
    mmp_result_if result,
    output int    fail_count,
    output int    outstanding,
    output int    words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [PORT_W-1:0] port;
        msg_t              msg;
        logic              last;
    } parsed_word_t;

    parsed_word_t expected_words[$];
    phase_t       port_phase [NUM_PORTS];
    logic [7:0]   port_status [NUM_PORTS];
    logic [7:0]   port_first [NUM_PORTS];
    logic [15:0]  sysex_len [NUM_PORTS];
    logic         sysex_dropping [NUM_PORTS];
    logic [6:0]   enabled_ports;
    logic [15:0]  sysex_limit;
    int           errors = 0;
    int           checked = 0;

    function automatic logic takes_one_data(input logic [7:0] s);
        return s[7:4] == HI_PROG_CHANGE || s[7:4] == HI_PRESSURE;
    endfunction

    function automatic logic takes_two_data(input logic [7:0] s);
        return (s[7:4] >= HI_NOTE_OFF && s[7:4] <= HI_CONTROL) || s[7:4] == HI_PITCH_BEND;
    endfunction

    function automatic msg_t make_msg(input logic kind, input logic [7:0] b0,
                                      input logic [7:0] b1, input logic [7:0] b2,
                                      input logic [1:0] count, input logic sx_end);
        msg_t m;
        m.kind        = kind;
        m.first_byte  = b0;
        m.second_byte = b1;
        m.third_byte  = b2;
        m.byte_count  = count;
        m.sysex_end   = sx_end;
        return m;
    endfunction

    // One byte on one port; returns 1 when it completes a word.
    function automatic logic parse_byte(input int p, input logic [7:0] b, output msg_t m);
        logic [7:0] st;
        logic       is_data;
        logic       emit;
        st      = port_status[p];
        is_data = !b[7];
        emit    = 1'b0;
        m       = '0;
        case (port_phase[p])
            PH_IDLE:
            begin
                if (b >= SINGLE_BYTE_LO && b != SYSEX_STOP)
                begin
                    m    = make_msg(KIND_SHORT, b, 8'h00, 8'h00, 2'd1, 1'b0);
                    emit = 1'b1;
                end
                else if (!is_data)
                begin
                    if (b != SYSEX_STOP)
                    begin
                        port_status[p] = b;
                        port_phase[p]  = PH_STATUS;
                    end
                end
                else if (takes_one_data(st))
                begin
                    m    = make_msg(KIND_SHORT, st, b, 8'h00, 2'd2, 1'b0);
                    emit = 1'b1;
                end
                else if (takes_two_data(st))
                begin
                    port_first[p] = b;
                    port_phase[p] = PH_DATA;
                end
            end
            PH_STATUS:
            begin
                if (takes_one_data(st) || st == TIME_CODE || st == SONG_SELECT)
                begin
                    port_phase[p] = PH_IDLE;
                    if (is_data)
                    begin
                        m    = make_msg(KIND_SHORT, st, b, 8'h00, 2'd2, 1'b0);
                        emit = 1'b1;
                    end
                end
                else if (is_data)
                begin
                    port_first[p] = b;
                    port_phase[p] = PH_DATA;
                end
                else
                begin
                    port_phase[p] = PH_IDLE;
                end
            end
            PH_DATA:
            begin
                if (st == SYSEX_START)
                begin
                    m    = make_msg(KIND_SYSEX, SYSEX_START, port_first[p], b, 2'd3,
                                    b == SYSEX_STOP);
                    emit = 1'b1;
                    if (b == SYSEX_STOP)
                    begin
                        port_phase[p]  = PH_IDLE;
                        port_status[p] = 8'h00;
                    end
                    else
                    begin
                        port_phase[p]     = PH_SYSEX;
                        sysex_len[p]      = 16'd3;
                        sysex_dropping[p] = 1'b0;
                    end
                end
                else
                begin
                    port_phase[p] = PH_IDLE;
                    if (is_data && (takes_two_data(st) || st == SONG_POSITION))
                    begin
                        m    = make_msg(KIND_SHORT, st, port_first[p], b, 2'd3, 1'b0);
                        emit = 1'b1;
                    end
                end
            end
            default:
            begin
                if (b == SYSEX_STOP)
                begin
                    m                 = make_msg(KIND_SYSEX, b, 8'h00, 8'h00, 2'd1, 1'b1);
                    emit              = 1'b1;
                    port_phase[p]     = PH_IDLE;
                    port_status[p]    = 8'h00;
                    sysex_len[p]      = 16'd0;
                    sysex_dropping[p] = 1'b0;
                end
                else if (!sysex_dropping[p] && sysex_len[p] < sysex_limit)
                begin
                    sysex_len[p] = sysex_len[p] + 16'd1;
                    m            = make_msg(KIND_SYSEX, b, 8'h00, 8'h00, 2'd1, 1'b0);
                    emit         = 1'b1;
                end
                else
                begin
                    sysex_dropping[p] = 1'b1;
                end
            end
        endcase
        return emit;
    endfunction

    function automatic void predict_packet();
        logic [7:0]   rx [NUM_PORTS];
        logic [6:0]   active;
        msg_t         m;
        parsed_word_t held;
        logic         have_held;
        rx[0]     = packet.port0_byte;
        rx[1]     = packet.port1_byte;
        rx[2]     = packet.port2_byte;
        rx[3]     = packet.port3_byte;
        rx[4]     = packet.port4_byte;
        rx[5]     = packet.port5_byte;
        rx[6]     = packet.port6_byte;
        active    = packet.valid_mask & enabled_ports;
        have_held = 1'b0;
        held      = '0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if (active[p] && parse_byte(p, rx[p], m))
            begin
                if (have_held)
                    expected_words.push_back(held);
                held.port = PORT_W'(p);
                held.msg  = m;
                held.last = 1'b0;
                have_held = 1'b1;
            end
        end
        if (have_held)
        begin
            held.last = 1'b1;
            expected_words.push_back(held);
        end
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] seen);
        if (seen !== want)
        begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, seen);
        end
    endfunction

    function automatic void check_word();
        parsed_word_t want;
        if (expected_words.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected word, port %0d first byte 0x%0h", $time,
                     result.source_port, result.first_byte);
            return;
        end
        want = expected_words.pop_front();
        checked++;
        compare_field("source_port", 8'(want.port), 8'(result.source_port));
        compare_field("kind", 8'(want.msg.kind), 8'(result.kind));
        compare_field("first_byte", want.msg.first_byte, result.first_byte);
        compare_field("second_byte", want.msg.second_byte, result.second_byte);
        compare_field("third_byte", want.msg.third_byte, result.third_byte);
        compare_field("byte_count", 8'(want.msg.byte_count), 8'(result.byte_count));
        compare_field("sysex_end", 8'(want.msg.sysex_end), 8'(result.sysex_end));
        compare_field("last_of_packet", 8'(want.last), 8'(result.last_of_packet));
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_words.delete();
            for (int p = 0; p < NUM_PORTS; p++)
            begin
                port_phase[p]     = PH_IDLE;
                port_status[p]    = 8'h00;
                port_first[p]     = 8'h00;
                sysex_len[p]      = 16'd0;
                sysex_dropping[p] = 1'b0;
            end
            enabled_ports = '1;
            sysex_limit   = '1;
            outstanding   <= 0;
            fail_count    <= errors;
            words_checked <= checked;
        end
        else
        begin
            // result first: a word leaving on this edge never belongs to
            // a packet accepted on the same edge
            if (result.valid && result.ready)
                check_word();
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_PORT_ENABLE: enabled_ports = cfg.data[6:0];
                    CFG_MAX_SYSEX:   sysex_limit   = cfg.data;
                    default:         ;
                endcase
            end
            if (packet.valid && packet.ready)
                predict_packet();
            outstanding   <= expected_words.size();
            fail_count    <= errors;
            words_checked <= checked;
        end
    end

endmodule

// ----- tb/sv/tb_midi_multiport_message_parser.sv -----
// ----------------------------------------------------------------------------
// tb_midi_multiport_message_parser
// Stimulus and verdict for the multiport MIDI parser. A scripted opener hits
// running status, broken messages, system common and sysex corner cases on
// all seven ports. Random packets then draw from per-port streams of mostly
// well-formed messages over several port-enable and sysex-limit settings,
// with random stalls on both sides and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_midi_multiport_message_parser;
    import mmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int GAP_PCT       = 26;

    logic clk;
    logic rst_n;
    logic calm;
    int   holds_asked;
    int   packets_sent;
    int   settings_used;
    int   fail_count;
    int   outstanding;
    int   words_checked;

    logic [7:0] port_stream [NUM_PORTS][$];

    mmp_packet_if packet_ch ();
    mmp_cfg_if    cfg_ch ();
    mmp_result_if result_ch ();

    midi_multiport_message_parser uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .packet (packet_ch),
        .cfg    (cfg_ch),
        .result (result_ch)
    );

    midi_word_checker word_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .packet        (packet_ch),
        .cfg           (cfg_ch),
        .result        (result_ch),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .words_checked (words_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

    // receiver: random stalls, plus a long hold-off whenever one is asked
    initial
    begin
        int holds_done;
        holds_done = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (holds_asked != holds_done)
            begin
                holds_done++;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            result_ch.ready <= calm || $urandom_range(99) >= GAP_PCT;
        end
    end

    function automatic logic [7:0] data_byte();
        return {1'b0, 7'($urandom_range(127))};
    endfunction

    function automatic void queue_bytes(input int p, input logic [127:0] seq, input int n);
        for (int i = 0; i < n; i++)
            port_stream[p].push_back(seq[(n - 1 - i) * 8 +: 8]);
    endfunction

    function automatic void add_message(input int p);
        int         roll;
        int         groups;
        int         len;
        logic [7:0] st;
        logic [7:0] b;
        roll   = $urandom_range(99);
        groups = ($urandom_range(3) == 0) ? $urandom_range(4, 2) : 1;
        if (roll < 30)
        begin
            st = {($urandom_range(3) == 0) ? HI_PITCH_BEND
                                           : 4'($urandom_range(HI_CONTROL, HI_NOTE_OFF)),
                  4'($urandom_range(15))};
            port_stream[p].push_back(st);
            repeat (groups)
            begin
                port_stream[p].push_back(data_byte());
                port_stream[p].push_back(data_byte());
            end
        end
        else if (roll < 45)
        begin
            st = {$urandom_range(1) ? HI_PROG_CHANGE : HI_PRESSURE, 4'($urandom_range(15))};
            port_stream[p].push_back(st);
            repeat (groups)
                port_stream[p].push_back(data_byte());
        end
        else if (roll < 55)
        begin
            case ($urandom_range(2))
                0: port_stream[p].push_back(TIME_CODE);
                1: port_stream[p].push_back(SONG_SELECT);
                default:
                begin
                    port_stream[p].push_back(SONG_POSITION);
                    port_stream[p].push_back(data_byte());
                end
            endcase
            port_stream[p].push_back(data_byte());
        end
        else if (roll < 63)
        begin
            do
                b = 8'($urandom_range(255, SINGLE_BYTE_LO));
            while (b == SYSEX_STOP);
            port_stream[p].push_back(b);
        end
        else if (roll < 80)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(60, 9) : $urandom_range(8);
            port_stream[p].push_back(SYSEX_START);
            for (int i = 0; i < len; i++)
            begin
                b = data_byte();
                if (i >= 2 && $urandom_range(6) == 0)
                begin
                    do
                        b = 8'($urandom_range(255, 128));
                    while (b == SYSEX_STOP);
                end
                port_stream[p].push_back(b);
            end
            port_stream[p].push_back(SYSEX_STOP);
        end
        else if (roll < 90)
        begin
            // often a truncated message; a status byte that follows cuts a short message short
            port_stream[p].push_back(8'($urandom_range(SONG_SELECT, 8'h80)));
            if ($urandom_range(1))
                port_stream[p].push_back(data_byte());
        end
        else
        begin
            port_stream[p].push_back(8'($urandom_range(255)));
        end
    endfunction

    task automatic push_packet(input logic [6:0] mask, input logic [55:0] bytes);
        while (!calm && $urandom_range(99) < GAP_PCT)
        begin
            packet_ch.valid <= 1'b0;
            @(posedge clk);
        end
        packet_ch.valid      <= 1'b1;
        packet_ch.valid_mask <= mask;
        packet_ch.port0_byte <= bytes[7:0];
        packet_ch.port1_byte <= bytes[15:8];
        packet_ch.port2_byte <= bytes[23:16];
        packet_ch.port3_byte <= bytes[31:24];
        packet_ch.port4_byte <= bytes[39:32];
        packet_ch.port5_byte <= bytes[47:40];
        packet_ch.port6_byte <= bytes[55:48];
        do
            @(posedge clk);
        while (!packet_ch.ready);
        packets_sent++;
    endtask

    // one packet from the port streams; absent ports carry junk bytes
    task automatic send_row(input bit refill, input int present_pct, output int left);
        logic [6:0]  mask;
        logic [55:0] bytes;
        left = 0;
        for (int p = 0; p < NUM_PORTS; p++)
        begin
            if (refill && port_stream[p].size() == 0)
                add_message(p);
            if (port_stream[p].size() != 0 && $urandom_range(99) < present_pct)
            begin
                mask[p]          = 1'b1;
                bytes[p * 8 +: 8] = port_stream[p].pop_front();
            end
            else
            begin
                mask[p]          = 1'b0;
                bytes[p * 8 +: 8] = 8'($urandom_range(255));
            end
            left += port_stream[p].size();
        end
        push_packet(mask, bytes);
    endtask

    task automatic drain();
        packet_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [6:0] ports, input logic [15:0] limit);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= CFG_PORT_ENABLE;
        cfg_ch.data  <= {9'd0, ports};
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.index <= CFG_MAX_SYSEX;
        cfg_ch.data  <= limit;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    task automatic run_phase(input logic [6:0] ports, input logic [15:0] limit,
                             input int count, input int present_pct, input bit hold_sink);
        int left;
        drain();
        set_config(ports, limit);
        if (hold_sink)
            holds_asked <= holds_asked + 1;
        repeat (count)
            send_row(1'b1, present_pct, left);
    endtask

    initial
    begin
        int left;
        rst_n                <= 1'b0;
        calm                 <= 1'b0;
        holds_asked          <= 0;
        packets_sent          = 0;
        settings_used         = 0;
        packet_ch.valid      <= 1'b0;
        packet_ch.valid_mask <= '0;
        packet_ch.port0_byte <= '0;
        packet_ch.port1_byte <= '0;
        packet_ch.port2_byte <= '0;
        packet_ch.port3_byte <= '0;
        packet_ch.port4_byte <= '0;
        packet_ch.port5_byte <= '0;
        packet_ch.port6_byte <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= CFG_PORT_ENABLE;
        cfg_ch.data          <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: a full packet of single-byte messages, an empty mask
        push_packet(7'h7f, 56'hff_fe_fc_fb_fa_f9_f8);
        push_packet(7'h00, 56'({$urandom(), $urandom()}));
        queue_bytes(0, 128'(96'h90_3c_7f_40_00_95_80_85_01_f8_02_03), 12);
        queue_bytes(1, 128'(96'hc3_05_06_d0_7f_7e_b1_07_64_c0_d0_00), 12);
        queue_bytes(2, 128'(104'hf7_f2_10_20_f1_33_f3_7f_f4_f5_f6_ff_01), 13);
        queue_bytes(3, 128'(88'h00_f0_f7_f0_11_f7_f0_01_02_03_f7), 11);
        queue_bytes(4, 128'(72'hf0_7d_01_02_90_f8_00_f7_05), 9);
        queue_bytes(5, 128'(104'he0_00_7f_7f_7f_b0_07_90_40_41_f2_01_f0), 13);
        queue_bytes(6, 128'(112'h80_00_00_8f_7f_7f_ef_7f_7f_f0_7f_7f_7f_f7), 14);
        do
            send_row(1'b0, 100, left);
        while (left != 0);

        // shortest sysex limit with port five switched off
        drain();
        set_config(7'h5f, 16'd4);
        for (int p = 0; p < NUM_PORTS; p++)
            queue_bytes(p, 128'(56'hf0_01_02_03_04_05_f7), 7);
        do
            send_row(1'b0, 100, left);
        while (left != 0);

        run_phase(7'h7f, 16'hffff, 115, 75, 1'b0);
        run_phase(7'h55, 16'd6, 60, 75, 1'b0);
        run_phase(7'h00, 16'd4, 12, 75, 1'b0);
        calm <= 1'b1;
        run_phase(7'h7f, 16'd4, 80, 75, 1'b0);
        calm <= 1'b0;
        run_phase(7'h2a, 16'd9, 55, 75, 1'b0);
        run_phase(7'h7f, 16'hffff, 115, 100, 1'b1);
        drain();

        $display("summary: %0d packets sent, %0d words checked, %0d register settings",
                 packets_sent, words_checked, settings_used);
        $display("summary: running status, system common, sysex overflow and output hold-off");
        if (fail_count == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
